// ===== rtl/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/aes128_pkg.sv =====
package aes128_pkg;

	localparam int unsigned KeyWords = 44;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXP  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_RND  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef enum logic [0:0] {
		CFG_KEY_HIGH = 1'b0,
		CFG_KEY_LOW  = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] FWD_BOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_BOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
	endfunction

	// one column, forward (2,3,1,1) or inverse (e,b,d,9)
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m0 [4];
		logic [31:0] r;
		for (int k = 0; k < 4; k++) begin
			a[k] = c[31-8*k -: 8];
			a2[k] = xt(a[k]);
			a4[k] = xt(a2[k]);
			a8[k] = xt(a4[k]);
			if (inv) begin
				m0[k] = a8[k] ^ a4[k] ^ a2[k];
				m1[k] = a8[k] ^ a2[k] ^ a[k];
				m2[k] = a8[k] ^ a4[k] ^ a[k];
				m3[k] = a8[k] ^ a[k];
			end else begin
				m0[k] = a2[k];
				m1[k] = a2[k] ^ a[k];
				m2[k] = a[k];
				m3[k] = a[k];
			end
		end
		for (int rr = 0; rr < 4; rr++) begin
			r[31-8*rr -: 8] = m0[rr] ^ m1[(rr+1)%4] ^ m2[(rr+2)%4] ^ m3[(rr+3)%4];
		end
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		logic [7:0] v;
		case (i)
			4'd0: v = 8'h01;
			4'd1: v = 8'h02;
			4'd2: v = 8'h04;
			4'd3: v = 8'h08;
			4'd4: v = 8'h10;
			4'd5: v = 8'h20;
			4'd6: v = 8'h40;
			4'd7: v = 8'h80;
			4'd8: v = 8'h1b;
			4'd9: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/aes128_block_cipher.sv =====
// Sequence: an accepted transaction runs 11 key additions before a valid result, each
//   reading its round key word by word on the single memory port and then applying it;
//   key expansion of all 44 words runs first on the first block after reset or a key write.
// Flow: one block in flight, so a new block is not taken until the last one is done; input is
//   taken while a result waits, and only the last round stalls until the result is free.
// Reset: arst_n clears control, key registers, working block and the keys-ready flag;
//   the round-key memory is not cleared and is always expanded before use.
`include "assert_macros.svh"
module aes128_block_cipher import aes128_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // block_high[63:0], block_low[127:64]
	input  logic         s_tuser,   // action: 0 encrypt, 1 decrypt
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // result_high[63:0], result_low[127:64]
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data
);

	// key registers and ready flag
	logic [63:0] key_hi_q, key_lo_q;
	logic        keys_ready_q;

	// round-key memory: 44 words, one write and one registered read per cycle
	logic [31:0] rk_mem [KeyWords];
	logic        rk_we;
	logic [5:0]  rk_waddr, rk_raddr;
	logic [31:0] rk_wdata, rk_rdata;

	always_ff @(posedge clk) begin
		if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
		rk_rdata <= rk_mem[rk_raddr];
	end

	state_t      state_q;
	logic [5:0]  idx_q;     // expansion word index
	logic [127:0] w_hist_q; // last four expanded words, newest in low bits
	logic [3:0]  rnd_q;     // round counter
	logic [1:0]  col_q;     // column being keyed
	logic        dec_q;
	logic [127:0] st_q;     // working block, byte 0 at top
	logic [127:0] hold_q;   // block latched at acceptance
	logic [127:0] out_q;
	logic         out_vld_q;

	// result register parts input from output: a waiting result only holds the last round
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q[63:0], out_q[127:64]};

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	logic out_free, out_load;
	assign out_free = !out_vld_q || m_tready;
	assign out_load = (state_q == ST_RND) && (rnd_q == 4'd10) && out_free;

	// expansion next word
	logic [31:0] prev_w, temp_w, new_w;
	always_comb begin
		prev_w = w_hist_q[31:0];
		if (idx_q[1:0] == 2'd0)
			temp_w = sub_word({prev_w[23:0], prev_w[31:24]})
				^ {rcon(idx_q[5:2] - 4'd1), 24'h0};
		else
			temp_w = prev_w;
		new_w = w_hist_q[127:96] ^ temp_w;
	end

	// round transform on the whole block (one round per step)
	logic [127:0] sb, sr, mc, rk_full;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sb[127-8*i -: 8] = dec_q ? INV_BOX[st_q[127-8*i -: 8]]
				: FWD_BOX[st_q[127-8*i -: 8]];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (dec_q)
					sr[127-8*(r+4*((c+r)%4)) -: 8] = sb[127-8*(r+4*c) -: 8];
				else
					sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			mc[127-32*c -: 32] = mix_col(sr[127-32*c -: 32], 1'b0);
		end
	end

	// round keys come one word a cycle; a round takes 4 reads, so the first three
	// words are gathered in rk_acc_q and the fourth is taken from the read port.
	logic [127:0] rk_acc_q;
	logic [2:0]   rd_cnt_q;  // words fetched for the current key (pipelined read)
	logic [3:0]   key_sel;   // round key number to apply
	assign key_sel = dec_q ? 4'd10 - rnd_q : rnd_q;
	assign rk_full = {rk_acc_q[95:0], rk_rdata};

	// decrypt: after AddRoundKey apply inverse MixColumns (except first and last)
	logic [127:0] ark, imc;
	always_comb begin
		ark = (rnd_q == 4'd0) ? (hold_q ^ rk_full)
			: (dec_q ? (sr ^ rk_full) : (((rnd_q == 4'd10) ? sr : mc) ^ rk_full));
		for (int c = 0; c < 4; c++) begin
			imc[127-32*c -: 32] = mix_col(ark[127-32*c -: 32], 1'b1);
		end
	end

	always_comb begin
		rk_we = (state_q == ST_EXP);
		rk_waddr = idx_q;
		rk_wdata = (idx_q < 6'd4) ? ((idx_q[1]) ? (idx_q[0] ? key_lo_q[31:0] : key_lo_q[63:32])
			: (idx_q[0] ? key_hi_q[31:0] : key_hi_q[63:32])) : new_w;
		rk_raddr = {key_sel, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_hi_q <= '0;
			key_lo_q <= '0;
			keys_ready_q <= 1'b0;
			idx_q <= '0;
			rnd_q <= '0;
			col_q <= '0;
			rd_cnt_q <= '0;
			out_vld_q <= 1'b0;
			dec_q <= 1'b0;
			st_q <= '0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KEY_HIGH: key_hi_q <= cfg_data;
					CFG_KEY_LOW:  key_lo_q <= cfg_data;
					default: ;
				endcase
				keys_ready_q <= 1'b0;
			end
			if (out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						dec_q <= s_tuser;
						idx_q <= '0;
						rnd_q <= '0;
						col_q <= '0;
						rd_cnt_q <= '0;
						state_q <= keys_ready_q ? ST_LOAD : ST_EXP;
					end
				end
				ST_EXP: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'(KeyWords - 1)) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// issue reads of the round key words; last address held for ST_RND
					if (rd_cnt_q != 3'd3) col_q <= col_q + 2'd1;
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd3) state_q <= ST_RND;
				end
				ST_RND: begin
					// last word arrives now; apply and fetch next key, or store the last round once the output is free
					if (rnd_q != 4'd10 || out_free) begin
						col_q <= '0;
						rd_cnt_q <= '0;
						st_q <= (dec_q && rnd_q != 4'd10) ? ((rnd_q == 4'd0) ? ark : imc) : ark;
						if (rnd_q == 4'd10) begin
							out_q <= ark;
							state_q <= ST_DONE;
						end else begin
							rnd_q <= rnd_q + 4'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// data-side registers
	always_ff @(posedge clk) begin
		if (in_acc) hold_q <= {s_tdata[63:0], s_tdata[127:64]};
		if (state_q == ST_EXP) w_hist_q <= {w_hist_q[95:0], rk_wdata};
		if (state_q == ST_LOAD && rd_cnt_q != 3'd0)
			rk_acc_q <= {rk_acc_q[95:0], rk_rdata};
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !s_tready,
		"input accepted while busy")
	`ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == ST_DONE, m_tvalid || $past(m_tready),
		"result lost")
	`ASSERT_IMPL(a_exp_range, clk, arst_n, state_q == ST_EXP, idx_q < 6'(KeyWords),
		"expansion index out of range")

endmodule

// ===== bench/aes128_block_cipher_test.sv =====
`timescale 1ns / 100ps
module aes128_block_cipher_test import aes128_pkg::*;;

	// ---------------------------------------------------------------
	// Block-cipher testbench: key registers are loaded through the
	// config port, blocks go in on the slave stream and results come
	// back on the master stream. A local AES-128 model predicts each
	// result, and the checker compares results in order.
	// ---------------------------------------------------------------

	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned DrainCycles = 80;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // block_high[63:0], block_low[127:64]
	logic         s_tuser;   // action: 0 encrypt, 1 decrypt
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;   // result_high[63:0], result_low[127:64]
	logic         cfg_we;
	logic         cfg_index;
	logic [63:0]  cfg_data;

	aes128_block_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: key copy and expanded schedule
	logic [63:0]  key_hi_q;
	logic [63:0]  key_lo_q;
	logic [31:0]  sched_q [44];
	bit           sched_ok;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} block_t;

	block_t cipher_results_q [$];
	int     fail_count = 0;
	int     idle_cycles = 0;
	bit     rx_stall_mode = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// --- AES arithmetic (written apart from the package, but using its S-boxes) ---
	function automatic logic [7:0] gdouble(input logic [7:0] b);
		gdouble = (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				acc ^= a;
			a = gdouble(a);
		end
		gmul = acc;
	endfunction

	function automatic void expand_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		sched_q[0] = key_hi_q[63:32];
		sched_q[1] = key_hi_q[31:0];
		sched_q[2] = key_lo_q[63:32];
		sched_q[3] = key_lo_q[31:0];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = sched_q[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
				t[31:24] ^= rc;
				rc = gdouble(rc);
			end
			sched_q[i] = sched_q[i-4] ^ t;
		end
		sched_ok = 1'b1;
	endfunction

	// state byte k: row k%4, column k/4
	function automatic void add_round(ref logic [7:0] s [16], input int rnd);
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				s[4*c+k] ^= sched_q[rnd*4+c][31-8*k -: 8];
	endfunction

	function automatic void shift(ref logic [7:0] s [16], input bit inv);
		logic [7:0] t [16];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (inv)
					t[r+4*((c+r)%4)] = s[r+4*c];
				else
					t[r+4*c] = s[r+4*((c+r)%4)];
		s = t;
	endfunction

	function automatic void mix(ref logic [7:0] s [16], input bit inv);
		logic [7:0] col [4];
		logic [7:0] m [4];
		logic [7:0] v;
		if (inv)
			m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else
			m = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++)
				col[r] = s[4*c+r];
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++)
					v ^= gmul(col[k], m[(k-r+4)%4]);
				s[4*c+r] = v;
			end
		end
	endfunction

	function automatic block_t aes_transform(input bit dec, input block_t din);
		logic [7:0] s [16];
		block_t res;
		if (!sched_ok)
			expand_schedule();
		for (int i = 0; i < 8; i++) begin
			s[i]   = din.hi[63-8*i -: 8];
			s[i+8] = din.lo[63-8*i -: 8];
		end
		if (!dec) begin
			add_round(s, 0);
			for (int r = 1; r <= 10; r++) begin
				for (int i = 0; i < 16; i++)
					s[i] = FWD_BOX[s[i]];
				shift(s, 1'b0);
				if (r != 10)
					mix(s, 1'b0);
				add_round(s, r);
			end
		end else begin
			add_round(s, 10);
			for (int r = 9; r >= 0; r--) begin
				shift(s, 1'b1);
				for (int i = 0; i < 16; i++)
					s[i] = INV_BOX[s[i]];
				add_round(s, r);
				if (r != 0)
					mix(s, 1'b1);
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63-8*i -: 8] = s[i];
			res.lo[63-8*i -: 8] = s[i+8];
		end
		aes_transform = res;
	endfunction

	// --- drivers ---

	// only while idle: nothing outstanding and the block has settled
	task automatic write_key(input cfg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KEY_HIGH)
			key_hi_q = val;
		else
			key_lo_q = val;
		sched_ok = 1'b0;
	endtask

	// one transaction on the slave side; valid stays up for a following send,
	// callers drop it before any gap
	task automatic send_block(input bit dec, input logic [63:0] hi, input logic [63:0] lo);
		block_t din;
		din.hi = hi;
		din.lo = lo;
		s_tvalid <= 1'b1;
		s_tuser  <= dec;
		s_tdata  <= {lo, hi};
		do
			@(posedge clk);
		while (!s_tready);
		cipher_results_q.push_back(aes_transform(dec, din));
	endtask

	// random block with occasional all-zero / all-one halves
	task automatic send_random(input bit dec);
		logic [63:0] hi;
		logic [63:0] lo;
		hi = {$urandom, $urandom};
		lo = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: hi = '0;
			1: lo = '1;
			default: ;
		endcase
		send_block(dec, hi, lo);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (cipher_results_q.size() != 0)
			@(posedge clk);
		// block may still be finishing internally
		repeat (20) @(posedge clk);
	endtask

	// sender bursts with random gaps
	task automatic send_bursts(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 8);
			for (int i = 0; i < burst && left > 0; i++, left--)
				send_random($urandom_range(0, 1));
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	endtask

	// --- checker: in-order compare on every master transaction ---
	always @(posedge clk) begin
		block_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_results_q.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				fail_count++;
			end else begin
				want = cipher_results_q.pop_front();
				if (m_tdata[63:0] !== want.hi) begin
					$error("result_high: expected %h, got %h", want.hi, m_tdata[63:0]);
					fail_count++;
				end
				if (m_tdata[127:64] !== want.lo) begin
					$error("result_low: expected %h, got %h", want.lo, m_tdata[127:64]);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern: alternates between free-running and stalling stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			rx_stall_mode <= ~rx_stall_mode;
		if (rx_stall_mode)
			m_tready <= ($urandom_range(0, 2) == 0);
		else
			m_tready <= 1'b1;
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// --- tests ---

	// FIPS-197 appendix vector, both directions, and extreme data
	task automatic test_directed();
		write_key(CFG_KEY_HIGH, 64'h0001020304050607);
		write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(1'b0, '0, '0);
		send_block(1'b0, '1, '1);
		send_block(1'b1, '0, '0);
		send_block(1'b1, '1, '1);
		send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		send_block(1'b1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		wait_idle();
	endtask

	// extreme keys; one register written, then a block forces re-expansion
	task automatic test_key_extremes();
		write_key(CFG_KEY_HIGH, '1);
		write_key(CFG_KEY_LOW, '1);
		send_block(1'b0, '0, '0);
		send_block(1'b1, '1, '0);
		wait_idle();
		write_key(CFG_KEY_HIGH, '0);
		send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
		wait_idle();
		write_key(CFG_KEY_LOW, '0);
		send_block(1'b0, '1, '1);
		wait_idle();
	endtask

	// random blocks under several random keys
	task automatic test_random_keys();
		for (int phase = 0; phase < 6; phase++) begin
			write_key(CFG_KEY_HIGH, {$urandom, $urandom});
			write_key(CFG_KEY_LOW, {$urandom, $urandom});
			send_bursts(62);
			wait_idle();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_KEY_HIGH;
		cfg_data      = '0;
		key_hi_q      = '0;
		key_lo_q      = '0;
		sched_ok      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first block after reset runs on the zero key
		send_block(1'b0, '0, '0);
		wait_idle();

		test_directed();
		test_key_extremes();
		test_random_keys();

		while (cipher_results_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aes128_pkg.sv
rtl/aes128_block_cipher.sv
bench/aes128_block_cipher_test.sv
